// ===== rtl/wbo_pkg.sv =====
package wbo_pkg;

  localparam int unsigned NumBands   = 3;
  localparam int unsigned PosW       = 8;
  localparam int unsigned CfgW       = 9;
  localparam int unsigned NumOutFlds = 12;
  localparam logic [CfgW-1:0] ChartHeightRst = 9'd200;
  localparam logic [PosW-1:0] HullLoInit = 8'd255;
  localparam logic [PosW-1:0] HullHiInit = 8'd0;

  typedef logic [PosW-1:0] pos_t;

  typedef struct packed {
    pos_t [NumBands-1:0] ys;
    pos_t [NumBands-1:0] ye;
    pos_t [NumBands-1:0] h;
  } span_t;

  typedef struct packed {
    span_t         span;
    logic [1:0]    covered;
    pos_t [1:0]    lo;
    pos_t [1:0]    hi;
  } hull_t;

  typedef pos_t [NumOutFlds-1:0] seg_t;

endpackage

// ===== rtl/waveform_band_occlusion.sv =====
// Visible bar segments of three stacked waveform bands, one point per word.
// Input stream: one word carries the low, mid and high band heights. Output
// stream: one word carries top and bottom segment (start, length) per band.
// Configuration: cfg_we_i writes cfg_wdata_i into chart_height; write it
// only while no word is in flight. Bars center at chart_height / 2.
// Pipeline: input accept to output valid passes through the bar position,
// occluder hull, and clamp and segment registers, in that order.
// Throughput: one word per cycle while the output is not stalled; every stage
// has its own valid bit and ready, so words follow with no bubble.
// Stall: when m_axis_tready is low the output word holds; earlier stages
// keep filling until all three hold a word, then s_axis_tready drops. No word
// is lost or repeated.
// Reset: clears all valid bits and loads chart_height with 200.
module waveform_band_occlusion (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [8:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // low_height, mid_height, high_height
  input  logic [23:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // low_top_y, low_top_len, low_bot_y, low_bot_len, mid_top_y, mid_top_len,
  // mid_bot_y, mid_bot_len, high_top_y, high_top_len, high_bot_y, high_bot_len
  output logic [95:0] m_axis_tdata
);

  logic [wbo_pkg::CfgW-1:0] chart_height_q;
  wbo_pkg::pos_t [wbo_pkg::NumBands-1:0] height;
  wbo_pkg::span_t span;
  wbo_pkg::hull_t hull;
  wbo_pkg::seg_t  seg;
  logic span_valid, span_ready, hull_valid, hull_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chart_height_q <= wbo_pkg::ChartHeightRst;
    end else if (cfg_we_i) begin
      chart_height_q <= cfg_wdata_i;
    end
  end

  assign height = s_axis_tdata;

  wbo_span u_span (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .height_i    (height),
    .half_i      (chart_height_q[wbo_pkg::CfgW-1:1]),
    .out_valid_o (span_valid),
    .out_ready_i (span_ready),
    .out_o       (span)
  );

  wbo_hull u_hull (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (span_valid),
    .in_ready_o  (span_ready),
    .in_i        (span),
    .out_valid_o (hull_valid),
    .out_ready_i (hull_ready),
    .out_o       (hull)
  );

  wbo_seg u_seg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (hull_valid),
    .in_ready_o  (hull_ready),
    .in_i        (hull),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (seg)
  );

  assign m_axis_tdata = seg;

endmodule

// ===== rtl/wbo_span.sv =====
module wbo_span (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  wbo_pkg::pos_t [wbo_pkg::NumBands-1:0] height_i,
  input  wbo_pkg::pos_t                  half_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output wbo_pkg::span_t                 out_o
);

  logic           valid_q;
  wbo_pkg::span_t span_d, span_q;

  always_comb begin
    for (int i = 0; i < wbo_pkg::NumBands; i++) begin
      span_d.h[i]  = height_i[i];
      span_d.ys[i] = half_i - {1'b0, height_i[i][wbo_pkg::PosW-1:1]};
      span_d.ye[i] = span_d.ys[i] + height_i[i];
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = span_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      span_q <= span_d;
    end
  end

endmodule

// ===== rtl/wbo_hull.sv =====
module wbo_hull (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  wbo_pkg::span_t in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output wbo_pkg::hull_t out_o
);

  logic           valid_q;
  wbo_pkg::hull_t hull_d, hull_q;
  logic           ov;

  always_comb begin
    hull_d.span    = in_i;
    hull_d.covered = '0;
    ov             = 1'b0;
    for (int c = 0; c < 2; c++) begin
      hull_d.lo[c] = wbo_pkg::HullLoInit;
      hull_d.hi[c] = wbo_pkg::HullHiInit;
      for (int k = c + 1; k < wbo_pkg::NumBands; k++) begin
        ov = !((in_i.ye[k] <= in_i.ys[c]) || (in_i.ys[k] >= in_i.ye[c]));
        if (ov) begin
          hull_d.covered[c] = 1'b1;
          if (in_i.ys[k] < hull_d.lo[c]) hull_d.lo[c] = in_i.ys[k];
          if (in_i.ye[k] > hull_d.hi[c]) hull_d.hi[c] = in_i.ye[k];
        end
      end
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = hull_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      hull_q <= hull_d;
    end
  end

endmodule

// ===== rtl/wbo_seg.sv =====
module wbo_seg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  wbo_pkg::hull_t in_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output wbo_pkg::seg_t  out_o
);

  logic          valid_q;
  wbo_pkg::seg_t seg_d, seg_q;
  wbo_pkg::pos_t lo, hi;

  always_comb begin
    seg_d = '0;
    lo    = '0;
    hi    = '0;
    for (int c = 0; c < 2; c++) begin
      if (!in_i.covered[c]) begin
        seg_d[4*c]   = in_i.span.ys[c];
        seg_d[4*c+1] = in_i.span.h[c];
      end else begin
        lo = (in_i.lo[c] < in_i.span.ys[c]) ? in_i.span.ys[c] : in_i.lo[c];
        hi = (in_i.hi[c] > in_i.span.ye[c]) ? in_i.span.ye[c] : in_i.hi[c];
        if (in_i.span.ys[c] < lo) begin
          seg_d[4*c]   = in_i.span.ys[c];
          seg_d[4*c+1] = lo - in_i.span.ys[c];
        end
        if (in_i.span.ye[c] > hi) begin
          seg_d[4*c+2] = hi;
          seg_d[4*c+3] = in_i.span.ye[c] - hi;
        end
      end
    end
    seg_d[8] = in_i.span.ys[2];
    seg_d[9] = in_i.span.h[2];
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_o       = seg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      seg_q <= seg_d;
    end
  end

endmodule

// ===== bench/waveform_band_occlusion_tb.sv =====
`timescale 1ns / 100ps

module waveform_band_occlusion_tb;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned LongHoldAt    = 400;
  localparam int unsigned LongHoldLen   = 300;
  localparam int unsigned DrainCycles   = 10;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic [8:0]  cfg_wdata_i   = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;

  logic [23:0] band_heights_q [$];
  logic [95:0] seg_expected_q [$];
  logic [8:0]  chart_height_model = wbo_pkg::ChartHeightRst;
  bit          idle_en = 1'b1;
  int unsigned mismatches = 0;
  int unsigned src_gap = 0;
  int unsigned sink_hold = 0;
  int unsigned words_seen = 0;
  bit          long_hold_done = 1'b0;
  int unsigned stuck_cycles = 0;
  logic [95:0] seg_got;
  logic [95:0] seg_want;

  string seg_field_name [12] = '{
    "low_top_y", "low_top_len", "low_bot_y", "low_bot_len",
    "mid_top_y", "mid_top_len", "mid_bot_y", "mid_bot_len",
    "high_top_y", "high_top_len", "high_bot_y", "high_bot_len"
  };

  waveform_band_occlusion u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic logic [95:0] occlusion_segments(logic [23:0] heights,
                                                     logic [8:0] chart_h);
    wbo_pkg::pos_t half;
    wbo_pkg::pos_t h  [3];
    wbo_pkg::pos_t ys [3];
    wbo_pkg::pos_t ye [3];
    wbo_pkg::pos_t hull_lo;
    wbo_pkg::pos_t hull_hi;
    bit            covered;
    logic [95:0]   segs;
    half = chart_h[8:1];
    segs = '0;
    for (int i = 0; i < 3; i++) begin
      h[i]  = heights[8*i +: 8];
      ys[i] = half - (h[i] >> 1);
      ye[i] = ys[i] + h[i];
    end
    for (int c = 0; c < 3; c++) begin
      hull_lo = wbo_pkg::HullLoInit;
      hull_hi = wbo_pkg::HullHiInit;
      covered = 1'b0;
      for (int k = c + 1; k < 3; k++) begin
        if (!(ye[k] <= ys[c] || ys[k] >= ye[c])) begin
          covered = 1'b1;
          if (ys[k] < hull_lo) hull_lo = ys[k];
          if (ye[k] > hull_hi) hull_hi = ye[k];
        end
      end
      if (!covered) begin
        segs[32*c +: 8]     = ys[c];
        segs[32*c + 8 +: 8] = h[c];
      end else begin
        if (hull_lo < ys[c]) hull_lo = ys[c];
        if (hull_hi > ye[c]) hull_hi = ye[c];
        if (ys[c] < hull_lo) begin
          segs[32*c +: 8]     = ys[c];
          segs[32*c + 8 +: 8] = wbo_pkg::pos_t'(hull_lo - ys[c]);
        end
        if (ye[c] > hull_hi) begin
          segs[32*c + 16 +: 8] = hull_hi;
          segs[32*c + 24 +: 8] = wbo_pkg::pos_t'(ye[c] - hull_hi);
        end
      end
    end
    return segs;
  endfunction

  function automatic wbo_pkg::pos_t pick_height();
    wbo_pkg::pos_t edge_vals [4] = '{8'd0, 8'd1, 8'd254, 8'd255};
    if ($urandom_range(0, 7) == 0) return edge_vals[$urandom_range(0, 3)];
    return wbo_pkg::pos_t'($urandom_range(0, 255));
  endfunction

  task automatic queue_random(int unsigned count);
    for (int n = 0; n < count; n++) begin
      band_heights_q.push_back({pick_height(), pick_height(), pick_height()});
    end
  endtask

  task automatic queue_directed();
    band_heights_q.push_back({8'd0, 8'd0, 8'd0});
    band_heights_q.push_back({8'd255, 8'd255, 8'd255});
    band_heights_q.push_back({8'd0, 8'd0, 8'd255});
    band_heights_q.push_back({8'd0, 8'd255, 8'd0});
    band_heights_q.push_back({8'd255, 8'd0, 8'd0});
    band_heights_q.push_back({8'd30, 8'd20, 8'd10});
    band_heights_q.push_back({8'd10, 8'd20, 8'd30});
    band_heights_q.push_back({8'd100, 8'd50, 8'd100});
    band_heights_q.push_back({8'd3, 8'd2, 8'd1});
    band_heights_q.push_back({8'd253, 8'd255, 8'd254});
    band_heights_q.push_back({8'd150, 8'd100, 8'd200});
    band_heights_q.push_back({8'd1, 8'd254, 8'd255});
  endtask

  task automatic wait_idle();
    do begin
      repeat (DrainCycles) @(negedge clk_i);
    end while (band_heights_q.size() != 0 || s_axis_tvalid ||
               seg_expected_q.size() != 0);
  endtask

  task automatic write_chart_height(logic [8:0] value);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    chart_height_model = value;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        seg_expected_q.push_back(occlusion_segments(s_axis_tdata, chart_height_model));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (band_heights_q.size() > 0) begin
          s_axis_tdata  <= band_heights_q.pop_front();
          s_axis_tvalid <= 1'b1;
          if (idle_en && $urandom_range(0, 7) == 0) src_gap = $urandom_range(1, 6);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        seg_got = m_axis_tdata;
        words_seen++;
        if (seg_expected_q.size() == 0) begin
          $error("result word with no expectation: %h", seg_got);
          mismatches++;
        end else begin
          seg_want = seg_expected_q.pop_front();
          for (int f = 0; f < 12; f++) begin
            if (seg_got[8*f +: 8] !== seg_want[8*f +: 8]) begin
              $error("%s expected %0d actual %0d", seg_field_name[f],
                     seg_want[8*f +: 8], seg_got[8*f +: 8]);
              mismatches++;
            end
          end
        end
      end
      if (sink_hold > 0) begin
        sink_hold--;
        m_axis_tready <= 1'b0;
      end else if (!long_hold_done && words_seen >= LongHoldAt) begin
        long_hold_done = 1'b1;
        sink_hold = LongHoldLen - 1;
        m_axis_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        sink_hold = $urandom_range(1, 6) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
      if (stuck_cycles >= WatchdogLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    queue_directed();
    queue_random(250);

    write_chart_height(9'd0);
    queue_directed();
    queue_random(300);

    write_chart_height(9'd511);
    queue_random(300);

    write_chart_height(9'd1);
    queue_random(250);

    write_chart_height(9'd256);
    queue_random(250);

    write_chart_height(9'($urandom_range(0, 511)));
    queue_random(250);

    write_chart_height(9'd200);
    queue_random(200);

    write_chart_height(9'($urandom_range(0, 511)));
    idle_en = 1'b0;
    queue_random(200);

    wait_idle();
    if (mismatches == 0 && seg_expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== waveform_band_occlusion.f =====
rtl/wbo_pkg.sv
rtl/wbo_span.sv
rtl/wbo_hull.sv
rtl/wbo_seg.sv
rtl/waveform_band_occlusion.sv
bench/waveform_band_occlusion_tb.sv
